@@ rtl/hfd_pkg.sv @@
// shared types and constants for the huffman tree stream decoder
// no dependencies; imported by hfd_front, hfd_outq, hfd_back and the top module
package hfd_pkg;

    localparam logic [7:0] ESC_CHAR   = 8'h5C;
    localparam logic [7:0] NODE_CHAR  = 8'h2A;
    localparam int         PAD_SHIFT  = 5;
    localparam int         PAD_WIDTH  = 3;
    localparam int         OUTQ_DEPTH = 16;
    localparam int         OUTQ_AW    = 4;
    // worst case one byte writes eight results
    localparam int         OUTQ_ROOM  = OUTQ_DEPTH - 8;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       status;
        logic       end_of_run;
    } t_out_item;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
        logic       is_esc;
        logic       is_node;
    } t_front_item;

    typedef struct packed {
        logic      wr;
        t_out_item item;
    } t_res_wr;

    typedef enum logic [3:0] {
        PH_HDR1 = 4'b0001,
        PH_HDR2 = 4'b0010,
        PH_TREE = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_TREE   = 6'b000010,
        S_ADD    = 6'b000100,
        S_DSTART = 6'b001000,
        S_DBIT   = 6'b010000,
        S_DFLUSH = 6'b100000
    } t_bstate;

endpackage

@@ rtl/hfd_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module hfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hfd_front.sv @@
// front end: two entry item queue that tags escape and node marker bytes
// depends on hfd_pkg
module hfd_front
    import hfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_take,
    output t_front_item o_item
);

    t_front_item r_q [2];
    logic        r_wp, n_wp;
    logic        r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    logic        w_push_ok;
    logic        w_take_ok;
    t_front_item w_tagged;

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign o_item    = r_q[r_rp];
    assign w_push_ok = i_push && !o_full;
    assign w_take_ok = i_take && o_valid;

    always_comb begin
        w_tagged.in_byte   = i_item.in_byte;
        w_tagged.last_byte = i_item.last_byte;
        w_tagged.is_esc    = (i_item.in_byte == ESC_CHAR);
        w_tagged.is_node   = (i_item.in_byte == NODE_CHAR);
        n_wp  = w_push_ok ? ~r_wp : r_wp;
        n_rp  = w_take_ok ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push_ok} - {1'b0, w_take_ok};
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wp] <= w_tagged;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ rtl/hfd_outq.sv @@
// result queue between the decode sequencer and the output ports
// depends on hfd_pkg
module hfd_outq
    import hfd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_wr   i_wr,
    output logic      o_room,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    t_out_item          r_mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] r_wp, r_rp;
    logic [OUTQ_AW:0]   r_cnt;
    logic               w_pop_ok;

    assign o_empty  = (r_cnt == '0);
    assign o_room   = (r_cnt <= (OUTQ_AW + 1)'(OUTQ_ROOM));
    assign o_item   = r_mem[r_rp];
    assign w_pop_ok = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr) begin
            r_mem[r_wp] <= i_wr.item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + OUTQ_AW'(i_wr.wr);
            r_rp  <= r_rp + OUTQ_AW'(w_pop_ok);
            r_cnt <= r_cnt + (OUTQ_AW + 1)'(i_wr.wr) - (OUTQ_AW + 1)'(w_pop_ok);
        end
    end

endmodule

@@ rtl/hfd_back.sv @@
// back end: header parse, tree build through node and stack memories, bit walk
// depends on hfd_pkg and hfd_ram
module hfd_back
    import hfd_pkg::*;
#(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_front_item i_item,
    output logic        o_take,
    input  logic        i_room,
    output t_res_wr     o_wr
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = NW + 1;
    localparam int SA = $clog2(STACK_DEPTH);
    localparam int LW = SA + 1;

    t_bstate     r_state, n_state;
    t_phase      r_phase, n_phase;
    t_front_item r_item, n_item;
    logic [2:0]  r_pad, n_pad;
    logic [12:0] r_tlen, n_tlen;
    logic [12:0] r_tseen, n_tseen;
    logic        r_esc, n_esc;
    logic [LW-1:0] r_level, n_level;
    logic [CW-1:0] r_nfn, n_nfn;
    logic        r_prev_leaf, n_prev_leaf;
    logic        r_root_leaf, n_root_leaf;
    logic        r_err, n_err;
    logic [NW-1:0] r_root_l, n_root_l;
    logic [NW-1:0] r_root_r, n_root_r;
    logic [NW-1:0] r_wl, n_wl;
    logic [NW-1:0] r_wr, n_wr;
    logic        r_at_root, n_at_root;
    logic [2:0]  r_bi, n_bi;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_do_add, n_do_add;
    logic        r_add_leaf, n_add_leaf;
    t_out_item   r_hold, n_hold;
    logic        r_hold_v, n_hold_v;

    // node memories: leaf flag with symbol, left child, right child
    logic          w_ls_we;
    logic [NW-1:0] w_ls_waddr;
    logic [8:0]    w_ls_wdata, w_ls_q;
    logic          w_l_we, w_r_we;
    logic [NW-1:0] w_l_waddr, w_r_waddr, w_l_wdata, w_r_wdata, w_l_q, w_r_q;
    logic [NW-1:0] w_raddr;
    logic          w_s_we;
    logic [SA-1:0] w_s_waddr, w_s_raddr;
    logic [NW-1:0] w_s_wdata, w_s_q;

    logic          w_fail, w_clear;
    logic [CW-1:0] w_n;
    logic [LW-1:0] w_lvl;
    logic [LW-1:0] w_lvl_dec;
    logic [NW-1:0] w_base_l, w_base_r;
    logic [7:0]    w_b;
    logic [12:0]   w_tlen_lo;
    logic [3:0]    w_nb;
    logic          w_sym_bit;

    hfd_ram #(.WIDTH(9), .DEPTH(MAX_NODES)) u_ls_ram (
        .i_clk(i_clk), .i_we(w_ls_we), .i_waddr(w_ls_waddr), .i_wdata(w_ls_wdata),
        .i_raddr(w_raddr), .o_rdata(w_ls_q)
    );
    hfd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_l_ram (
        .i_clk(i_clk), .i_we(w_l_we), .i_waddr(w_l_waddr), .i_wdata(w_l_wdata),
        .i_raddr(w_raddr), .o_rdata(w_l_q)
    );
    hfd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_r_ram (
        .i_clk(i_clk), .i_we(w_r_we), .i_waddr(w_r_waddr), .i_wdata(w_r_wdata),
        .i_raddr(w_raddr), .o_rdata(w_r_q)
    );
    hfd_ram #(.WIDTH(NW), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_waddr), .i_wdata(w_s_wdata),
        .i_raddr(w_s_raddr), .o_rdata(w_s_q)
    );

    assign w_b       = r_item.in_byte;
    assign w_lvl_dec = r_level - LW'(1);
    assign w_s_raddr = w_lvl_dec[SA-1:0];

    always_comb begin
        n_state = r_state;     n_phase = r_phase;       n_item = r_item;
        n_pad = r_pad;         n_tlen = r_tlen;         n_tseen = r_tseen;
        n_esc = r_esc;         n_level = r_level;       n_nfn = r_nfn;
        n_prev_leaf = r_prev_leaf;  n_root_leaf = r_root_leaf;  n_err = r_err;
        n_root_l = r_root_l;   n_root_r = r_root_r;     n_wl = r_wl;
        n_wr = r_wr;           n_at_root = r_at_root;   n_bi = r_bi;
        n_cnt = r_cnt;         n_do_add = r_do_add;     n_add_leaf = r_add_leaf;
        n_hold = r_hold;       n_hold_v = r_hold_v;
        o_take = 1'b0;
        o_wr   = '0;
        w_ls_we = 1'b0; w_ls_waddr = '0; w_ls_wdata = '0;
        w_l_we = 1'b0;  w_l_waddr = '0;  w_l_wdata = '0;
        w_r_we = 1'b0;  w_r_waddr = '0;  w_r_wdata = '0;
        w_s_we = 1'b0;  w_s_waddr = '0;  w_s_wdata = '0;
        w_raddr = '0;
        w_fail = 1'b0;
        w_clear = 1'b0;
        w_n = r_nfn;
        w_lvl = r_level;
        w_base_l = r_at_root ? r_root_l : r_wl;
        w_base_r = r_at_root ? r_root_r : r_wr;
        w_tlen_lo = {r_tlen[12:8], i_item.in_byte};
        w_nb = (r_item.last_byte && (r_pad != 3'd0)) ? (4'd8 - {1'b0, r_pad}) : 4'd8;
        w_sym_bit = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid && i_room) begin
                    o_take = 1'b1;
                    n_item = i_item;
                    if (r_err) begin
                        w_clear = i_item.last_byte;
                    end else begin
                        case (r_phase)
                            PH_HDR1: begin
                                n_pad   = i_item.in_byte[PAD_SHIFT +: PAD_WIDTH];
                                n_tlen  = {i_item.in_byte[4:0], 8'h00};
                                n_phase = PH_HDR2;
                                w_fail  = i_item.last_byte;
                                w_clear = i_item.last_byte;
                            end
                            PH_HDR2: begin
                                n_tlen = w_tlen_lo;
                                if (w_tlen_lo == 13'd0) begin
                                    w_fail = 1'b1;
                                end else begin
                                    n_phase = PH_TREE;
                                end
                                w_fail  = w_fail || i_item.last_byte;
                                w_clear = i_item.last_byte;
                            end
                            PH_TREE: n_state = S_TREE;
                            PH_DATA: n_state = S_DSTART;
                            default: n_state = S_IDLE;
                        endcase
                    end
                end
            end
            S_TREE: begin
                n_tseen  = r_tseen + 13'd1;
                n_do_add = 1'b0;
                // bytes after a complete tree are skipped
                if (!((r_nfn != '0) && (r_level == '0))) begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        n_do_add = 1'b1;
                        n_add_leaf = 1'b1;
                    end else if (r_item.is_esc) begin
                        n_esc = 1'b1;
                    end else begin
                        n_do_add = 1'b1;
                        n_add_leaf = !r_item.is_node;
                    end
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                if (r_do_add) begin
                    w_n = r_nfn;
                    if (w_n >= CW'(MAX_NODES)) begin
                        w_fail = 1'b1;
                    end else begin
                        if (w_n != '0) begin
                            if (!r_prev_leaf) begin
                                w_l_we    = 1'b1;
                                w_l_waddr = NW'(w_n - CW'(1));
                                w_l_wdata = w_n[NW-1:0];
                                if (w_l_waddr == '0) begin
                                    n_root_l = w_n[NW-1:0];
                                end
                            end else if (r_level == '0) begin
                                w_fail = 1'b1;
                            end else begin
                                // pop: the top of the stack was read in the previous cycle
                                w_lvl     = w_lvl_dec;
                                w_r_we    = 1'b1;
                                w_r_waddr = w_s_q;
                                w_r_wdata = w_n[NW-1:0];
                                if (w_s_q == '0) begin
                                    n_root_r = w_n[NW-1:0];
                                end
                            end
                        end
                        if (!w_fail) begin
                            w_ls_we    = 1'b1;
                            w_ls_waddr = w_n[NW-1:0];
                            w_ls_wdata = {r_add_leaf, r_add_leaf ? w_b : 8'h00};
                            n_nfn      = w_n + CW'(1);
                            n_prev_leaf = r_add_leaf;
                            if (w_n == '0) begin
                                n_root_leaf = r_add_leaf;
                            end
                            if (!r_add_leaf) begin
                                if (w_lvl >= LW'(STACK_DEPTH)) begin
                                    w_fail = 1'b1;
                                end else begin
                                    w_s_we    = 1'b1;
                                    w_s_waddr = w_lvl[SA-1:0];
                                    w_s_wdata = w_n[NW-1:0];
                                    w_lvl     = w_lvl + LW'(1);
                                end
                            end
                        end
                    end
                    n_level = w_lvl;
                end
                if (!w_fail && (r_tseen == r_tlen)) begin
                    if ((n_nfn == '0) || (n_level != '0) || r_esc || n_root_leaf) begin
                        w_fail = 1'b1;
                    end else begin
                        n_phase   = PH_DATA;
                        n_at_root = 1'b1;
                    end
                end
                if (!w_fail && r_item.last_byte && (n_phase != PH_DATA)) begin
                    w_fail = 1'b1;
                end
                w_clear = r_item.last_byte;
                n_state = S_IDLE;
            end
            S_DSTART: begin
                w_raddr = w_b[7] ? w_base_r : w_base_l;
                n_bi    = 3'd6;
                n_cnt   = w_nb;
                n_state = S_DBIT;
            end
            S_DBIT: begin
                if (w_ls_q[8]) begin
                    // a result is held back a step so the last one of the item can be marked
                    if (r_hold_v) begin
                        o_wr.wr   = 1'b1;
                        o_wr.item = r_hold;
                    end
                    n_hold    = '{out_symbol: w_ls_q[7:0], status: 1'b0, end_of_run: 1'b0};
                    n_hold_v  = 1'b1;
                    n_at_root = 1'b1;
                    w_base_l  = r_root_l;
                    w_base_r  = r_root_r;
                end else begin
                    n_at_root = 1'b0;
                    n_wl      = w_l_q;
                    n_wr      = w_r_q;
                    w_base_l  = w_l_q;
                    w_base_r  = w_r_q;
                end
                n_cnt = r_cnt - 4'd1;
                if (r_cnt > 4'd1) begin
                    w_sym_bit = w_b[r_bi];
                    w_raddr   = w_sym_bit ? w_base_r : w_base_l;
                    n_bi      = r_bi - 3'd1;
                end else begin
                    n_state = S_DFLUSH;
                end
            end
            S_DFLUSH: begin
                if (r_hold_v) begin
                    o_wr.wr   = 1'b1;
                    o_wr.item = '{out_symbol: r_hold.out_symbol, status: 1'b0,
                                  end_of_run: 1'b1};
                    n_hold_v  = 1'b0;
                end
                w_clear = r_item.last_byte;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        if (w_fail) begin
            o_wr.wr   = 1'b1;
            o_wr.item = '{out_symbol: 8'h00, status: 1'b1, end_of_run: 1'b1};
            n_err     = 1'b1;
        end
        // end of file: everything back to the reset picture
        if (w_clear) begin
            n_phase = PH_HDR1;  n_pad = '0;  n_tlen = '0;  n_tseen = '0;
            n_esc = 1'b0;       n_level = '0;  n_nfn = '0;
            n_prev_leaf = 1'b0; n_root_leaf = 1'b0;  n_err = 1'b0;
            n_at_root = 1'b1;   n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_root_l   <= n_root_l;
        r_root_r   <= n_root_r;
        r_wl       <= n_wl;
        r_wr       <= n_wr;
        r_bi       <= n_bi;
        r_cnt      <= n_cnt;
        r_do_add   <= n_do_add;
        r_add_leaf <= n_add_leaf;
        r_hold     <= n_hold;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HDR1;
            r_pad       <= '0;
            r_tlen      <= '0;
            r_tseen     <= '0;
            r_esc       <= 1'b0;
            r_level     <= '0;
            r_nfn       <= '0;
            r_prev_leaf <= 1'b0;
            r_root_leaf <= 1'b0;
            r_err       <= 1'b0;
            r_at_root   <= 1'b1;
            r_hold_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pad       <= n_pad;
            r_tlen      <= n_tlen;
            r_tseen     <= n_tseen;
            r_esc       <= n_esc;
            r_level     <= n_level;
            r_nfn       <= n_nfn;
            r_prev_leaf <= n_prev_leaf;
            r_root_leaf <= n_root_leaf;
            r_err       <= n_err;
            r_at_root   <= n_at_root;
            r_hold_v    <= n_hold_v;
        end
    end

endmodule

@@ rtl/huffman_tree_stream_decoder.sv @@
// Huffman decoder for a byte stream: two header bytes (padding count, tree
// length), a preorder tree ('*' internal, backslash escapes a leaf byte), then
// packed code bits walked msb first, one symbol per leaf reached. Items queue in
// a two-entry front stage; a sequencer works one item at a time. A tree byte
// passes the tree and add states (the pop reads the pending-child stack memory
// before the node memories are written), a data byte the start, bit and flush
// states with one node memory read per code bit used (8, or 8 - padding on the
// last item). An item is started only while the result queue has room for eight
// results. A bad or single-leaf tree gives one error result, then nothing until
// the item flagged last, which resets all.
// depends on hfd_pkg, hfd_front, hfd_back, hfd_outq
module huffman_tree_stream_decoder
    import hfd_pkg::*;
#(
    parameter int MAX_NODES   = 512,
    parameter int STACK_DEPTH = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic        w_valid, w_take, w_room;
    t_front_item w_item;
    t_res_wr     w_wr;

    hfd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(i_in_item), .o_valid(w_valid), .i_take(w_take), .o_item(w_item)
    );

    hfd_back #(.MAX_NODES(MAX_NODES), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_valid), .i_item(w_item),
        .o_take(w_take), .i_room(w_room), .o_wr(w_wr)
    );

    hfd_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(w_wr), .o_room(w_room),
        .o_empty(empty), .i_pop(pop), .o_item(o_out_item)
    );

endmodule
